// File: rtl/epx_pkg.sv
`timescale 1ns / 1ps

package epx_pkg;

    localparam int PIX_W        = 32;
    localparam int FACTOR_W     = 4;
    localparam int NUM_COLS     = 10;
    localparam int MAX_FACTOR   = 10;
    localparam int MIN_FACTOR   = 2;
    localparam int RESET_FACTOR = 2;
    localparam int IN_W         = 5 * PIX_W;
    localparam int ROW_FIELDS_W = FACTOR_W + NUM_COLS * PIX_W;
    localparam int OUT_W        = ((ROW_FIELDS_W + 7) / 8) * 8;
    localparam int SUM_W        = 7;

    typedef logic [PIX_W-1:0]    t_pixel;
    typedef logic [FACTOR_W-1:0] t_factor;

    typedef struct packed {
        t_factor factor;
        t_pixel  centre;
        t_pixel  corner_nw;
        t_pixel  corner_ne;
        t_pixel  corner_sw;
        t_pixel  corner_se;
    } t_entry;

    function automatic logic is_opaque(input t_pixel px);
        return px[PIX_W-1 -: 8] != 8'd0;
    endfunction

    // Picks one subpixel's color: a corner, the centre, or zero.
    function automatic t_pixel sub_pixel(input t_entry e, input t_factor row,
                                         input t_factor col);
        logic [SUM_W-1:0] f;
        logic [SUM_W-1:0] r;
        logic [SUM_W-1:0] c;
        logic [SUM_W-1:0] s_tl;
        logic [SUM_W-1:0] s_tr;
        logic [SUM_W-1:0] s_bl;
        logic [SUM_W-1:0] s_br;
        t_pixel           px;
        f    = SUM_W'(e.factor);
        r    = SUM_W'(row);
        c    = SUM_W'(col);
        s_tl = (r + c + SUM_W'(1)) << 1;
        s_tr = (f - c + r) << 1;
        s_bl = (f + c - r) << 1;
        s_br = ((f << 1) - r - c - SUM_W'(1)) << 1;
        if (c >= f) begin
            px = '0;
        end else if (s_tl <= f) begin
            px = e.corner_nw;
        end else if (s_tr <= f) begin
            px = e.corner_ne;
        end else if (s_bl <= f) begin
            px = e.corner_sw;
        end else if (s_br <= f) begin
            px = e.corner_se;
        end else begin
            px = e.centre;
        end
        return px;
    endfunction

endpackage

// File: rtl/epx_front.sv
`timescale 1ns / 1ps

module epx_front import epx_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [IN_W-1:0]  i_data,
    input  t_factor          i_factor,
    output logic             o_push,
    output t_entry           o_entry,
    input  logic             i_queue_ready
);

    logic   r_valid;
    t_entry r_entry;
    t_entry n_entry;
    logic   n_factor_ok;
    logic   accept;
    t_pixel ctr;
    t_pixel up;
    t_pixel rt;
    t_pixel dn;
    t_pixel lf;
    t_pixel tl;
    t_pixel tr;
    t_pixel bl;
    t_pixel br;

    assign ctr = i_data[0*PIX_W +: PIX_W];
    assign up  = i_data[1*PIX_W +: PIX_W];
    assign rt  = i_data[2*PIX_W +: PIX_W];
    assign dn  = i_data[3*PIX_W +: PIX_W];
    assign lf  = i_data[4*PIX_W +: PIX_W];

    always_comb begin
        tl = (lf == up && lf != dn && up != rt) ? up : ctr;
        tr = (up == rt && up != lf && rt != dn) ? rt : ctr;
        bl = (dn == lf && dn != rt && lf != up) ? lf : ctr;
        br = (rt == dn && rt != lf && dn != up) ? dn : ctr;
        n_entry.factor    = i_factor;
        n_entry.centre    = ctr;
        n_entry.corner_nw = (is_opaque(ctr) && !is_opaque(tl)) ? ctr : tl;
        n_entry.corner_ne = (is_opaque(ctr) && !is_opaque(tr)) ? ctr : tr;
        n_entry.corner_sw = (is_opaque(ctr) && !is_opaque(bl)) ? ctr : bl;
        n_entry.corner_se = (is_opaque(ctr) && !is_opaque(br)) ? ctr : br;
        n_factor_ok = (i_factor >= FACTOR_W'(MIN_FACTOR))
                   && (i_factor <= FACTOR_W'(MAX_FACTOR));
    end

    assign o_ready = !r_valid || i_queue_ready;
    assign accept  = i_valid && o_ready;
    assign o_push  = r_valid;
    assign o_entry = r_entry;

    // An item taken while the factor is out of range produces nothing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= n_factor_ok;
        end else if (i_queue_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry <= n_entry;
        end
    end

endmodule

// File: rtl/epx_queue.sv
`timescale 1ns / 1ps

module epx_queue import epx_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_ready,
    input  logic   i_pop,
    output logic   o_valid,
    output t_entry o_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = r_count != CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// File: rtl/epx_back.sv
`timescale 1ns / 1ps

module epx_back import epx_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_queue_valid,
    input  t_entry           i_entry,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [OUT_W-1:0] o_data,
    output logic             o_last
);

    logic             r_busy;
    t_entry           r_cur;
    t_factor          r_row;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    logic             r_out_last;
    logic [OUT_W-1:0] n_out_data;
    logic             out_free;
    logic             emit;
    logic             last;
    logic             load;

    assign out_free = !r_out_valid || i_ready;
    assign emit     = r_busy && out_free;
    assign last     = r_row == (r_cur.factor - FACTOR_W'(1));
    assign load     = i_queue_valid && (!r_busy || (emit && last));
    assign o_pop    = load;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out_data;
    assign o_last   = r_out_last;

    always_comb begin
        n_out_data = '0;
        n_out_data[FACTOR_W-1:0] = r_row;
        for (int c = 0; c < NUM_COLS; c++) begin
            n_out_data[FACTOR_W + c*PIX_W +: PIX_W] =
                sub_pixel(r_cur, r_row, FACTOR_W'(c));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_row  <= '0;
            end else if (emit && last) begin
                r_busy <= 1'b0;
            end else if (emit) begin
                r_row <= r_row + FACTOR_W'(1);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur <= i_entry;
        end
        if (emit) begin
            r_out_data <= n_out_data;
            r_out_last <= last;
        end
    end

endmodule

// File: rtl/epx_edge_upscaler_core.sv
`timescale 1ns / 1ps
// The first output row of an item passes through the front register, the queue,
// the row generator's entry register and the output register.
// Throughput: one output row per cycle while the output is not stalled; the row
// generator emits the block one row at a time, scale_factor rows (2 to 10) each.
// Reset is synchronous and active low; it empties the pipeline and sets the
// scale factor to 2.

module epx_edge_upscaler_core import epx_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // centre_pixel, up_pixel, right_pixel, down_pixel, left_pixel
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // row_index, sub_0 .. sub_9, zero padding
    output logic [OUT_W-1:0] m_axis_tdata,
    output logic             m_axis_tlast,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [FACTOR_W-1:0] i_cfg_data
);

    t_factor r_scale_factor;
    logic    push;
    t_entry  push_entry;
    logic    queue_ready;
    logic    pop;
    logic    queue_valid;
    t_entry  head_entry;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_factor <= FACTOR_W'(RESET_FACTOR);
        end else if (i_cfg_valid) begin
            r_scale_factor <= i_cfg_data;
        end
    end

    epx_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_data        (s_axis_tdata),
        .i_factor      (r_scale_factor),
        .o_push        (push),
        .o_entry       (push_entry),
        .i_queue_ready (queue_ready)
    );

    epx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_ready (queue_ready),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_entry (head_entry)
    );

    epx_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_queue_valid (queue_valid),
        .i_entry       (head_entry),
        .o_pop         (pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_data        (m_axis_tdata),
        .o_last        (m_axis_tlast)
    );

endmodule
